### src/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants of the space-time constraint table.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int KEY_BITS   = 24;
  localparam int LOC_BITS   = 20;
  localparam int LCNT_BITS  = 21;
  localparam int PORT_TIME  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [1:0] {
    MODE_INSERT_INTERVAL = 2'd0,
    MODE_INSERT_LANDMARK = 2'd1,
    MODE_QUERY           = 2'd2,
    MODE_CLEAR           = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_CLASH = 2'd2,
    STATUS_RANGE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCATION_COUNT    = 3'd0,
    CFG_DUMMY_START_KEY   = 3'd1,
    CFG_MIN_LENGTH        = 3'd2,
    CFG_MAX_LENGTH        = 3'd3,
    CFG_AVOIDANCE_HORIZON = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

### src/stc_if.sv
// ----------------------------------------------------------------------------
// stc_if
// Request, result and configuration channels of the constraint table.
// ----------------------------------------------------------------------------
interface stc_in_if import stc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [KEY_BITS-1:0]  key;
  logic [PORT_TIME-1:0] time_start;
  logic [PORT_TIME-1:0] time_end;

  modport source (output valid, mode, key, time_start, time_end, input ready);
  modport sink (input valid, mode, key, time_start, time_end, output ready);
endinterface

interface stc_out_if import stc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 is_constrained;
  logic [1:0]           status;
  logic [PORT_TIME-1:0] static_after;

  modport source (output valid, is_constrained, status, static_after, input ready);
  modport sink (input valid, is_constrained, status, static_after, output ready);
endinterface

interface stc_cfg_if import stc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/space_time_constraint_table.sv
// Inserts and clears: pass EXEC and DONE; the result is then registered.
// Queries: EXEC, then SCAN until the token has walked the cell row, then DONE.
// One request at a time; a finished result may wait in the output register.
// Reset (synchronous, active low) and clear-all each start a sweep over
// all LANDMARK_SLOTS landmark RAM entries; no request is taken meanwhile.
// ----------------------------------------------------------------------------
// space_time_constraint_table
// Interval store in a cell row, landmark table in RAM, horizon tracking.
// ----------------------------------------------------------------------------
module space_time_constraint_table import stc_pkg::*; #(
  parameter int INTERVAL_ENTRIES = 256,
  parameter int LANDMARK_SLOTS   = 1024,
  parameter int TIME_BITS        = 16
) (
  input logic       clk,
  input logic       rst_n,
  stc_in_if.sink    in_req,
  stc_out_if.source out_rsp,
  stc_cfg_if.sink   cfg_req
);

  localparam int TW  = (TIME_BITS < PORT_TIME) ? TIME_BITS : PORT_TIME;
  localparam int CW  = $clog2(INTERVAL_ENTRIES + 1);
  localparam int AW  = $clog2(LANDMARK_SLOTS);
  localparam int LMW = LOC_BITS + 1;
  localparam logic [32:0] ALL_ONES = (33'd1 << TIME_BITS) - 33'd1;
  localparam logic [32:0] SLOTS    = 33'(LANDMARK_SLOTS);
  localparam bit HAS_FOREVER = (TIME_BITS <= PORT_TIME);

  state_t               state_r, state_nxt;
  mode_t                mode_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [TW-1:0]        ts_r;
  logic [TW-1:0]        te_r;
  logic [CW-1:0]        count_r;
  logic [TW-1:0]        lct_r;
  logic [TW-1:0]        llt_r;
  logic                 present_r;
  logic                 lm_hit_r;
  logic                 dummy_r;
  logic                 hit_r;
  status_t              status_r;
  logic [AW-1:0]        clr_idx_r;
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [1:0]           out_status_r;
  logic [PORT_TIME-1:0] out_after_r;

  logic [LCNT_BITS-1:0] loc_count_r;
  logic [KEY_BITS-1:0]  dummy_key_r;
  logic [PORT_TIME-1:0] min_len_r;
  logic [PORT_TIME-1:0] max_len_r;
  logic [PORT_TIME-1:0] avoid_r;

  logic                 accept;
  logic                 out_free;
  logic                 clr_last;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [LMW-1:0]       ram_wdata;
  logic [LMW-1:0]       ram_rdata;
  logic                 shift_en;
  logic                 launch;
  logic                 out_load;
  logic                 chain_valid;
  logic                 chain_hit;

  logic                 full;
  logic                 forever_end;
  logic                 in_range;
  logic                 lm_valid;
  logic                 loc_diff;
  logic                 is_vertex;
  logic [PORT_TIME-1:0] after;

  assign accept   = in_req.valid & in_req.ready;
  assign out_free = !out_valid_r || out_rsp.ready;
  assign clr_last = (clr_idx_r == AW'(LANDMARK_SLOTS - 1));

  always_comb begin
    full        = (count_r == CW'(INTERVAL_ENTRIES));
    forever_end = HAS_FOREVER && (te_r == '1);
    in_range    = (33'(ts_r) < SLOTS);
    lm_valid    = ram_rdata[LOC_BITS];
    loc_diff    = (ram_rdata[LOC_BITS-1:0] != key_r[LOC_BITS-1:0]);
    is_vertex   = (key_r < KEY_BITS'(loc_count_r));
  end

  always_comb begin
    after = PORT_TIME'(lct_r);
    if (avoid_r > after) begin
      after = avoid_r;
    end
    if (min_len_r > after) begin
      after = min_len_r;
    end
    if ((33'(max_len_r) < ALL_ONES) && (max_len_r > after)) begin
      after = max_len_r;
    end
    if (present_r && (PORT_TIME'(llt_r) > after)) begin
      after = PORT_TIME'(llt_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = (mode_r == MODE_QUERY) ? ST_SCAN : ST_DONE;
      ST_SCAN:  if (chain_valid) state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = (mode_r == MODE_CLEAR) ? ST_CLEAR : ST_IDLE;
        end
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_req.ready = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = AW'(ts_r);
    ram_wdata    = {1'b1, key_r[LOC_BITS-1:0]};
    shift_en     = 1'b0;
    launch       = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = '0;
      end
      ST_IDLE: in_req.ready = 1'b1;
      ST_EXEC: begin
        ram_we   = (mode_r == MODE_INSERT_LANDMARK) && in_range && !lm_valid;
        shift_en = (mode_r == MODE_INSERT_INTERVAL) && !full;
        launch   = (mode_r == MODE_QUERY);
      end
      ST_SCAN: ;
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      count_r     <= '0;
      lct_r       <= '0;
      llt_r       <= '0;
      present_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_last ? '0 : AW'(clr_idx_r + 1'b1);
      end
      if (state_r == ST_EXEC) begin
        case (mode_r)
          MODE_INSERT_INTERVAL: begin
            if (!full) begin
              count_r <= CW'(count_r + 1'b1);
              if (!forever_end) begin
                if (te_r > lct_r) lct_r <= te_r;
              end else if (ts_r > lct_r) begin
                lct_r <= ts_r;
              end
            end
          end
          MODE_INSERT_LANDMARK: begin
            if (in_range && !lm_valid) begin
              if (!present_r || (ts_r > llt_r)) llt_r <= ts_r;
              present_r <= 1'b1;
            end
          end
          MODE_CLEAR: begin
            count_r   <= '0;
            lct_r     <= '0;
            llt_r     <= '0;
            present_r <= 1'b0;
          end
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and per-request result
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_t'(in_req.mode);
      key_r  <= in_req.key;
      ts_r   <= TW'(in_req.time_start);
      te_r   <= TW'(in_req.time_end);
    end
    if (state_r == ST_EXEC) begin
      status_r <= STATUS_OK;
      hit_r    <= 1'b0;
      dummy_r  <= (key_r == dummy_key_r);
      lm_hit_r <= is_vertex && in_range && lm_valid && loc_diff;
      case (mode_r)
        MODE_INSERT_INTERVAL: if (full) status_r <= STATUS_FULL;
        MODE_INSERT_LANDMARK: begin
          if (!in_range) begin
            status_r <= STATUS_RANGE;
          end else if (lm_valid && loc_diff) begin
            status_r <= STATUS_CLASH;
          end
        end
        default: ;
      endcase
    end
    if ((state_r == ST_SCAN) && chain_valid) begin
      hit_r <= !dummy_r && (lm_hit_r || chain_hit);
    end
    if (out_load) begin
      out_hit_r    <= hit_r;
      out_status_r <= status_r;
      out_after_r  <= after;
    end
  end

  // configuration
  assign cfg_req.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_count_r <= LCNT_BITS'(1024);
      dummy_key_r <= '1;
      min_len_r   <= '0;
      max_len_r   <= '1;
      avoid_r     <= '0;
    end else if (cfg_req.valid) begin
      unique case (cfg_idx_t'(cfg_req.index))
        CFG_LOCATION_COUNT:    loc_count_r <= LCNT_BITS'(cfg_req.data);
        CFG_DUMMY_START_KEY:   dummy_key_r <= KEY_BITS'(cfg_req.data);
        CFG_MIN_LENGTH:        min_len_r   <= PORT_TIME'(cfg_req.data);
        CFG_MAX_LENGTH:        max_len_r   <= PORT_TIME'(cfg_req.data);
        CFG_AVOIDANCE_HORIZON: avoid_r     <= PORT_TIME'(cfg_req.data);
        default: ;
      endcase
    end
  end

  stc_ram #(.WIDTH(LMW), .DEPTH(LANDMARK_SLOTS)) u_landmarks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(TW'(in_req.time_start))),
    .rdata (ram_rdata)
  );

  stc_chain #(
    .N           (INTERVAL_ENTRIES),
    .TW          (TW),
    .CW          (CW),
    .HAS_FOREVER (HAS_FOREVER)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift_en   (shift_en),
    .new_key    (key_r),
    .new_start  (ts_r),
    .new_end    (te_r),
    .launch     (launch),
    .qry_key    (key_r),
    .qry_time   (ts_r),
    .qry_count  (count_r),
    .done_valid (chain_valid),
    .done_hit   (chain_hit)
  );

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.is_constrained = out_hit_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.static_after   = out_after_r;

endmodule

### src/stc_ram.sv
// ----------------------------------------------------------------------------
// stc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stc_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/stc_cell.sv
// ----------------------------------------------------------------------------
// stc_cell
// One interval slot: holds an entry and checks the passing query token.
// ----------------------------------------------------------------------------
module stc_cell import stc_pkg::*; #(
  parameter int TW          = 16,
  parameter int CW          = 9,
  parameter bit HAS_FOREVER = 1'b1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  logic [KEY_BITS-1:0] ent_key_i,
  input  logic [TW-1:0]       ent_start_i,
  input  logic [TW-1:0]       ent_end_i,
  output logic [KEY_BITS-1:0] ent_key_o,
  output logic [TW-1:0]       ent_start_o,
  output logic [TW-1:0]       ent_end_o,
  input  logic                tok_valid_i,
  input  logic [KEY_BITS-1:0] tok_key_i,
  input  logic [TW-1:0]       tok_time_i,
  input  logic [CW-1:0]       tok_left_i,
  input  logic                tok_hit_i,
  output logic                tok_valid_o,
  output logic [KEY_BITS-1:0] tok_key_o,
  output logic [TW-1:0]       tok_time_o,
  output logic [CW-1:0]       tok_left_o,
  output logic                tok_hit_o
);

  logic [KEY_BITS-1:0] key_r;
  logic [TW-1:0]       start_r;
  logic [TW-1:0]       end_r;
  logic                tv_r;
  logic [KEY_BITS-1:0] tk_r;
  logic [TW-1:0]       tt_r;
  logic [CW-1:0]       tl_r;
  logic                th_r;
  logic                active;
  logic                match;
  logic                th_nxt;
  logic [CW-1:0]       tl_nxt;

  always_comb begin
    active = (tok_left_i != '0);
    match  = (key_r == tok_key_i) && (start_r <= tok_time_i) &&
             ((HAS_FOREVER && (end_r == '1)) || (tok_time_i < end_r));
    th_nxt = tok_hit_i | (active & match);
    tl_nxt = active ? CW'(tok_left_i - 1'b1) : '0;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      key_r   <= ent_key_i;
      start_r <= ent_start_i;
      end_r   <= ent_end_i;
    end
    tk_r <= tok_key_i;
    tt_r <= tok_time_i;
    tl_r <= tl_nxt;
    th_r <= th_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else begin
      tv_r <= tok_valid_i;
    end
  end

  assign ent_key_o   = key_r;
  assign ent_start_o = start_r;
  assign ent_end_o   = end_r;
  assign tok_valid_o = tv_r;
  assign tok_key_o   = tk_r;
  assign tok_time_o  = tt_r;
  assign tok_left_o  = tl_r;
  assign tok_hit_o   = th_r;

endmodule

### src/stc_chain.sv
// ----------------------------------------------------------------------------
// stc_chain
// Row of interval cells; inserts shift in at the head, query tokens ripple
// one cell per cycle to the tail.
// ----------------------------------------------------------------------------
module stc_chain import stc_pkg::*; #(
  parameter int N           = 256,
  parameter int TW          = 16,
  parameter int CW          = 9,
  parameter bit HAS_FOREVER = 1'b1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [TW-1:0]       new_start,
  input  logic [TW-1:0]       new_end,
  input  logic                launch,
  input  logic [KEY_BITS-1:0] qry_key,
  input  logic [TW-1:0]       qry_time,
  input  logic [CW-1:0]       qry_count,
  output logic                done_valid,
  output logic                done_hit
);

  logic [KEY_BITS-1:0] ek [N];
  logic [TW-1:0]       es [N];
  logic [TW-1:0]       ee [N];
  logic                tv [N+1];
  logic [KEY_BITS-1:0] tk [N+1];
  logic [TW-1:0]       tt [N+1];
  logic [CW-1:0]       tl [N+1];
  logic                th [N+1];

  assign tv[0] = launch;
  assign tk[0] = qry_key;
  assign tt[0] = qry_time;
  assign tl[0] = qry_count;
  assign th[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [KEY_BITS-1:0] in_key;
    logic [TW-1:0]       in_start;
    logic [TW-1:0]       in_end;

    if (i == 0) begin : g_head
      assign in_key   = new_key;
      assign in_start = new_start;
      assign in_end   = new_end;
    end else begin : g_body
      assign in_key   = ek[i-1];
      assign in_start = es[i-1];
      assign in_end   = ee[i-1];
    end

    stc_cell #(.TW(TW), .CW(CW), .HAS_FOREVER(HAS_FOREVER)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shift_en    (shift_en),
      .ent_key_i   (in_key),
      .ent_start_i (in_start),
      .ent_end_i   (in_end),
      .ent_key_o   (ek[i]),
      .ent_start_o (es[i]),
      .ent_end_o   (ee[i]),
      .tok_valid_i (tv[i]),
      .tok_key_i   (tk[i]),
      .tok_time_i  (tt[i]),
      .tok_left_i  (tl[i]),
      .tok_hit_i   (th[i]),
      .tok_valid_o (tv[i+1]),
      .tok_key_o   (tk[i+1]),
      .tok_time_o  (tt[i+1]),
      .tok_left_o  (tl[i+1]),
      .tok_hit_o   (th[i+1])
    );
  end

  assign done_valid = tv[N];
  assign done_hit   = th[N];

endmodule

### tb/space_time_constraint_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// space_time_constraint_table_checker
// Watches the request, result and register channels of the constraint table,
// keeps its own copy of the interval store, landmark table and registers,
// works out the response to every accepted request and compares each
// accepted result with the oldest response still awaited.
// ----------------------------------------------------------------------------
module space_time_constraint_table_checker import stc_pkg::*; #(
  parameter int INTERVAL_ENTRIES = 256,
  parameter int LANDMARK_SLOTS   = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  stc_in_if           in_mon,
  stc_out_if          out_mon,
  stc_cfg_if          cfg_mon,
  output int unsigned outstanding,
  output int unsigned mismatches,
  output int unsigned checked
);

  typedef struct packed {
    logic                 hit;
    status_t              status;
    logic [PORT_TIME-1:0] horizon;
  } table_response_t;

  localparam logic [PORT_TIME-1:0] FOREVER = '1;

  logic [KEY_BITS-1:0]  iv_key   [INTERVAL_ENTRIES];
  logic [PORT_TIME-1:0] iv_start [INTERVAL_ENTRIES];
  logic [PORT_TIME-1:0] iv_end   [INTERVAL_ENTRIES];
  int unsigned          iv_count;
  bit                   lm_valid [LANDMARK_SLOTS];
  logic [LOC_BITS-1:0]  lm_loc   [LANDMARK_SLOTS];
  logic [PORT_TIME-1:0] latest_constraint;
  logic [PORT_TIME-1:0] latest_landmark;
  bit                   landmark_seen;

  logic [LCNT_BITS-1:0] location_count;
  logic [KEY_BITS-1:0]  dummy_key;
  logic [PORT_TIME-1:0] min_len;
  logic [PORT_TIME-1:0] max_len;
  logic [PORT_TIME-1:0] avoid_horizon;

  table_response_t awaited [$];

  function automatic void clear_table();
    iv_count = 0;
    foreach (lm_valid[i]) lm_valid[i] = 1'b0;
    latest_constraint = '0;
    latest_landmark   = '0;
    landmark_seen     = 1'b0;
  endfunction

  function automatic logic [PORT_TIME-1:0] static_horizon();
    logic [PORT_TIME-1:0] h;
    h = latest_constraint;
    if (avoid_horizon > h) h = avoid_horizon;
    if (min_len > h) h = min_len;
    if (max_len != FOREVER && max_len > h) h = max_len;
    if (landmark_seen && latest_landmark > h) h = latest_landmark;
    return h;
  endfunction

  function automatic logic key_blocked(logic [KEY_BITS-1:0] k, logic [PORT_TIME-1:0] t);
    if (k == dummy_key) return 1'b0;
    if (k < KEY_BITS'(location_count) && t < LANDMARK_SLOTS && lm_valid[t] &&
        lm_loc[t] != k[LOC_BITS-1:0])
      return 1'b1;
    for (int i = 0; i < iv_count; i++) begin
      if (iv_key[i] == k && iv_start[i] <= t && (iv_end[i] == FOREVER || t < iv_end[i]))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic table_response_t apply_request(mode_t m, logic [KEY_BITS-1:0] k,
                                                    logic [PORT_TIME-1:0] ts,
                                                    logic [PORT_TIME-1:0] te);
    table_response_t r;
    r.hit    = 1'b0;
    r.status = STATUS_OK;
    case (m)
      MODE_INSERT_INTERVAL: begin
        if (iv_count >= INTERVAL_ENTRIES) begin
          r.status = STATUS_FULL;
        end else begin
          iv_key[iv_count]   = k;
          iv_start[iv_count] = ts;
          iv_end[iv_count]   = te;
          iv_count++;
          if (te != FOREVER) begin
            if (te > latest_constraint) latest_constraint = te;
          end else if (ts > latest_constraint) begin
            latest_constraint = ts;
          end
        end
      end
      MODE_INSERT_LANDMARK: begin
        if (ts >= LANDMARK_SLOTS) begin
          r.status = STATUS_RANGE;
        end else if (lm_valid[ts]) begin
          if (lm_loc[ts] != k[LOC_BITS-1:0]) r.status = STATUS_CLASH;
        end else begin
          lm_valid[ts] = 1'b1;
          lm_loc[ts]   = k[LOC_BITS-1:0];
          if (!landmark_seen || ts > latest_landmark) latest_landmark = ts;
          landmark_seen = 1'b1;
        end
      end
      MODE_QUERY: begin
        r.hit = key_blocked(k, ts);
      end
      default: begin
        clear_table();
      end
    endcase
    r.horizon = static_horizon();
    return r;
  endfunction

  always @(posedge clk) begin
    table_response_t want;
    if (!rst_n) begin
      clear_table();
      location_count = 21'd1024;
      dummy_key      = '1;
      min_len        = '0;
      max_len        = FOREVER;
      avoid_horizon  = '0;
      awaited.delete();
      mismatches     = 0;
      checked        = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_t'(cfg_mon.index))
          CFG_LOCATION_COUNT:    location_count = cfg_mon.data[LCNT_BITS-1:0];
          CFG_DUMMY_START_KEY:   dummy_key      = cfg_mon.data[KEY_BITS-1:0];
          CFG_MIN_LENGTH:        min_len        = cfg_mon.data[PORT_TIME-1:0];
          CFG_MAX_LENGTH:        max_len        = cfg_mon.data[PORT_TIME-1:0];
          CFG_AVOIDANCE_HORIZON: avoid_horizon  = cfg_mon.data[PORT_TIME-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (awaited.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d arrived with no request outstanding", checked);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          if (out_mon.is_constrained !== want.hit || out_mon.status !== want.status ||
              out_mon.static_after !== want.horizon) begin
            if (mismatches < 10)
              $display("result %0d: expected hit %0b status %0d static_after %0d, got hit %0b status %0d static_after %0d",
                       checked, want.hit, want.status, want.horizon,
                       out_mon.is_constrained, out_mon.status, out_mon.static_after);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        awaited.push_back(apply_request(mode_t'(in_mon.mode), in_mon.key,
                                        in_mon.time_start, in_mon.time_end));
    end
    outstanding <= awaited.size();
  end

endmodule

### tb/space_time_constraint_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// space_time_constraint_table_tb
// Drives the constraint table with a directed set of requests at the reset
// register values, then random requests over several register settings,
// including a run that fills the interval store. Both sides stall at random
// but in one calm run; the checker beside the block predicts and compares all.
// ----------------------------------------------------------------------------
module space_time_constraint_table_tb;
  import stc_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned sent [4];
  int unsigned settings_used;

  logic [LCNT_BITS-1:0] cur_lc;
  logic [KEY_BITS-1:0]  cur_dummy;

  stc_in_if  req_ch ();
  stc_out_if rsp_ch ();
  stc_cfg_if cfg_ch ();

  space_time_constraint_table i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .cfg_req (cfg_ch)
  );

  space_time_constraint_table_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (req_ch),
    .out_mon     (rsp_ch),
    .cfg_mon     (cfg_ch),
    .outstanding (outstanding),
    .mismatches  (mismatches),
    .checked     (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 35);
    end
  end

  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return KEY_BITS'($urandom_range(0, 15));
      6, 7:             return KEY_BITS'(int'(cur_lc) + $urandom_range(0, 3) - 2);
      8:                return cur_dummy;
      default:          return KEY_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [PORT_TIME-1:0] pick_time();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: return PORT_TIME'($urandom_range(0, 48));
      7:                   return PORT_TIME'($urandom_range(1016, 1032));
      8:                   return PORT_TIME'($urandom_range(65528, 65535));
      default:             return PORT_TIME'($urandom);
    endcase
  endfunction

  function automatic logic [PORT_TIME-1:0] pick_end(logic [PORT_TIME-1:0] ts);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return ts + PORT_TIME'($urandom_range(0, 20));
      6, 7:             return '1;
      8:                return PORT_TIME'($urandom);
      default:          return ts - PORT_TIME'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic send_req(mode_t m, logic [KEY_BITS-1:0] k, logic [PORT_TIME-1:0] ts,
                          logic [PORT_TIME-1:0] te);
    while (!calm && $urandom_range(0, 99) < 35) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= m;
    req_ch.key        <= k;
    req_ch.time_start <= ts;
    req_ch.time_end   <= te;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent[m]++;
  endtask

  // hold the sender until every result is back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic write_settings(logic [LCNT_BITS-1:0] lc, logic [KEY_BITS-1:0] dummy,
                                logic [PORT_TIME-1:0] min_l, logic [PORT_TIME-1:0] max_l,
                                logic [PORT_TIME-1:0] avoid);
    write_reg(CFG_LOCATION_COUNT, CFG_DATA_W'(lc));
    write_reg(CFG_DUMMY_START_KEY, CFG_DATA_W'(dummy));
    write_reg(CFG_MIN_LENGTH, CFG_DATA_W'(min_l));
    write_reg(CFG_MAX_LENGTH, CFG_DATA_W'(max_l));
    write_reg(CFG_AVOIDANCE_HORIZON, CFG_DATA_W'(avoid));
    cfg_ch.valid <= 1'b0;
    cur_lc    = lc;
    cur_dummy = dummy;
    settings_used++;
  endtask

  task automatic run_phase(int n, int w_int, int w_lm, int w_q);
    int                   r;
    mode_t                m;
    logic [PORT_TIME-1:0] ts;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_int) m = MODE_INSERT_INTERVAL;
      else if (r < w_int + w_lm) m = MODE_INSERT_LANDMARK;
      else if (r < w_int + w_lm + w_q) m = MODE_QUERY;
      else m = MODE_CLEAR;
      ts = pick_time();
      send_req(m, pick_key(), ts, pick_end(ts));
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    calm              = 1'b0;
    settings_used     = 0;
    cur_lc            = 21'd1024;
    cur_dummy         = '1;
    req_ch.valid      = 1'b0;
    req_ch.mode       = MODE_QUERY;
    req_ch.key        = '0;
    req_ch.time_start = '0;
    req_ch.time_end   = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_LOCATION_COUNT;
    cfg_ch.data       = '0;
    foreach (sent[i]) sent[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(MODE_QUERY, 24'd0, 16'd0, 16'd0);
    send_req(MODE_INSERT_INTERVAL, 24'd5, 16'd10, 16'd20);
    send_req(MODE_QUERY, 24'd5, 16'd9, 16'd0);
    send_req(MODE_QUERY, 24'd5, 16'd10, 16'd0);
    send_req(MODE_QUERY, 24'd5, 16'd19, 16'd0);
    send_req(MODE_QUERY, 24'd5, 16'd20, 16'd0);
    send_req(MODE_INSERT_INTERVAL, 24'd7, 16'd100, 16'hFFFF);
    send_req(MODE_QUERY, 24'd7, 16'hFFFF, 16'd0);
    send_req(MODE_INSERT_LANDMARK, 24'd3, 16'd30, 16'd0);
    send_req(MODE_INSERT_LANDMARK, 24'd3, 16'd30, 16'd0);
    send_req(MODE_INSERT_LANDMARK, 24'd4, 16'd30, 16'd0);
    send_req(MODE_INSERT_LANDMARK, 24'h100003, 16'd30, 16'd0);
    send_req(MODE_INSERT_LANDMARK, 24'd1, 16'd1024, 16'd0);
    send_req(MODE_INSERT_LANDMARK, 24'd1, 16'hFFFF, 16'd0);
    send_req(MODE_QUERY, 24'd4, 16'd30, 16'd0);
    send_req(MODE_QUERY, 24'd3, 16'd30, 16'd0);
    send_req(MODE_QUERY, 24'd2000, 16'd30, 16'd0);
    send_req(MODE_INSERT_INTERVAL, 24'hFFFFFF, 16'd0, 16'hFFFE);
    send_req(MODE_QUERY, 24'hFFFFFF, 16'd5, 16'd0);
    send_req(MODE_INSERT_LANDMARK, 24'hFFFFFF, 16'd1023, 16'd0);
    send_req(MODE_QUERY, 24'd1, 16'd1023, 16'd0);
    send_req(MODE_INSERT_INTERVAL, 24'd0, 16'hFFFF, 16'd0);
    send_req(MODE_CLEAR, 24'd0, 16'd0, 16'd0);
    send_req(MODE_QUERY, 24'd5, 16'd10, 16'd0);
    drain();

    write_settings(21'd1, 24'd0, 16'd0, 16'd0, 16'd0);
    run_phase(90, 35, 20, 40);
    drain();

    calm = 1'b1;
    write_settings(21'h100000, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(90, 35, 20, 40);
    drain();
    calm = 1'b0;

    // start from an empty store so that it overflows
    write_settings(21'd16, 24'd3, 16'd40, 16'd1500, 16'd200);
    send_req(MODE_CLEAR, 24'd0, 16'd0, 16'd0);
    run_phase(280, 95, 0, 5);
    drain();

    write_settings(LCNT_BITS'($urandom_range(1, 1048576)), KEY_BITS'($urandom_range(0, 15)),
                   PORT_TIME'($urandom_range(0, 300)), PORT_TIME'($urandom_range(0, 2000)),
                   PORT_TIME'($urandom_range(0, 65535)));
    run_phase(70, 35, 20, 40);
    drain();

    repeat (300) @(posedge clk);
    $display("Covered %0d interval inserts, %0d landmark inserts, %0d queries, %0d clears",
             sent[MODE_INSERT_INTERVAL], sent[MODE_INSERT_LANDMARK], sent[MODE_QUERY],
             sent[MODE_CLEAR]);
    $display("over %0d register settings besides reset, with %0d results compared",
             settings_used, checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
